/* hw/rtl/cdm_pkg.sv */
// Package for the concentric disk map: request/result types, fixed-point
// constants and the CORDIC arc-tangent table. No dependencies.
`default_nettype none
package cdm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 30;

    localparam int OFS_W  = SAMPLE_BITS + 2;
    localparam int MAG_W  = SAMPLE_BITS + 1;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int PI4_W  = 30;
    localparam int PROD_W = QUO_W + PI4_W;
    localparam int PHI_W  = PROD_W - FRAC_BITS;
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int OUTP_W = OFS_W + XY_W;
    localparam int OSH    = SAMPLE_BITS + 15;

    localparam logic [PI4_W-1:0] PI4_Q30  = 30'd843314857;
    localparam logic [XY_W-1:0]  GAIN_Q30 = 34'd652032874;

    typedef struct packed {
        logic [15:0] sample_u0;
        logic [15:0] sample_u1;
    } request_t;

    typedef struct packed {
        logic signed [15:0] disk_x;
        logic signed [15:0] disk_y;
    } result_t;

    function automatic logic [29:0] arc_q30(input logic [4:0] k);
        logic [29:0] a;
        case (k)
            5'd0:  a = 30'd843314856;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043836;
            5'd3:  a = 30'd133525158;
            5'd4:  a = 30'd67021686;
            5'd5:  a = 30'd33543515;
            5'd6:  a = 30'd16775850;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194282;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048575;
            5'd11: a = 30'd524287;
            5'd12: a = 30'd262143;
            5'd13: a = 30'd131071;
            5'd14: a = 30'd65535;
            5'd15: a = 30'd32767;
            5'd16: a = 30'd16383;
            5'd17: a = 30'd8191;
            5'd18: a = 30'd4095;
            5'd19: a = 30'd2047;
            5'd20: a = 30'd1023;
            5'd21: a = 30'd511;
            5'd22: a = 30'd255;
            5'd23: a = 30'd127;
            5'd24: a = 30'd63;
            5'd25: a = 30'd31;
            5'd26: a = 30'd15;
            5'd27: a = 30'd7;
            5'd28: a = 30'd3;
            5'd29: a = 30'd1;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/concentric_disk_map.sv */
// Concentric disk map top level: offsets, radix-2 divider, angle scaling,
// CORDIC and output scaling, all as one pipeline. Depends on cdm_pkg.
//
// Usage: drive request and raise start; the request is taken at any edge
// where start is high, since busy is always low (a new request every cycle).
// Each request yields one result: done is high for one cycle with result
// valid in that cycle. Results come out in request order.
// Pipeline: CORDIC_STEPS + 36 register stages: 1 offset stage, 31 divider
// stages (one quotient bit each), 1 angle multiply, 1 angle round,
// CORDIC_STEPS rotation stages, 1 radius multiply and 1 round/saturate stage.
// The accepting edge loads the offset stage, and done rises together with
// the result from the round/saturate stage.
// Throughput: one request per cycle, set by the fully pipelined datapath.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module concentric_disk_map (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cdm_pkg::request_t request,
    output logic                   done,
    output cdm_pkg::result_t       result
);

    localparam int NB = cdm_pkg::SAMPLE_BITS;
    localparam int OW = cdm_pkg::OFS_W;
    localparam int MW = cdm_pkg::MAG_W;
    localparam int QW = cdm_pkg::QUO_W;
    localparam int CS = cdm_pkg::CORDIC_STEPS;
    localparam int XW = cdm_pkg::XY_W;
    localparam int ZW = cdm_pkg::Z_W;
    localparam int PW = cdm_pkg::OUTP_W;

    typedef struct packed {
        logic                 origin;
        logic                 xbr;
        logic                 neg;
        logic signed [OW-1:0] r;
    } side_t;

    assign busy = 1'b0;

    // offsets
    logic signed [OW-1:0] ox, oy;
    logic [MW-1:0]        ax, ay;
    side_t                s0_next;
    logic [MW-1:0]        num0, den0;

    always_comb
    begin
        ox = $signed({1'b0, request.sample_u0[NB-1:0], 1'b0}) - $signed(OW'(1) << NB);
        oy = $signed({1'b0, request.sample_u1[NB-1:0], 1'b0}) - $signed(OW'(1) << NB);
        ax = ox[OW-1] ? MW'(-ox) : MW'(ox);
        ay = oy[OW-1] ? MW'(-oy) : MW'(oy);
        s0_next.xbr    = ax > ay;
        s0_next.origin = (ax == '0) && (ay == '0);
        s0_next.neg    = ox[OW-1] != oy[OW-1];
        s0_next.r      = s0_next.xbr ? ox : oy;
        num0 = s0_next.xbr ? ay : ax;
        den0 = s0_next.xbr ? ax : ay;
    end

    // divider pipeline, index 0 is the offset stage
    logic          dv_vld_reg  [0:QW];
    side_t         dv_sd_reg   [0:QW];
    logic [MW-1:0] dv_rem_reg  [0:QW];
    logic [MW-1:0] dv_den_reg  [0:QW];
    logic [QW-1:0] dv_q_reg    [0:QW];
    logic [MW-1:0] dv_rem_next [1:QW];
    logic [QW-1:0] dv_q_next   [1:QW];

    always_comb
    begin
        logic [MW:0] trial;
        for (int k = 0; k < QW; k++)
        begin
            trial = (k == 0) ? {1'b0, dv_rem_reg[k]} : {dv_rem_reg[k], 1'b0};
            if (trial >= {1'b0, dv_den_reg[k]})
            begin
                dv_rem_next[k+1] = MW'(trial - {1'b0, dv_den_reg[k]});
                dv_q_next[k+1]   = {dv_q_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[k+1] = MW'(trial);
                dv_q_next[k+1]   = {dv_q_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    // angle
    logic                              am_vld_reg;
    side_t                             am_sd_reg;
    logic [cdm_pkg::PROD_W-1:0]        am_prod_reg;
    logic [cdm_pkg::PROD_W-1:0]        am_rnd;
    logic [cdm_pkg::PHI_W-1:0]         phi;

    always_comb
    begin
        am_rnd = am_prod_reg + (cdm_pkg::PROD_W'(1) << (cdm_pkg::FRAC_BITS - 1));
        phi    = am_rnd[cdm_pkg::PROD_W-1:cdm_pkg::FRAC_BITS];
    end

    // CORDIC pipeline
    logic                 cr_vld_reg [0:CS];
    side_t                cr_sd_reg  [0:CS];
    logic signed [XW-1:0] cr_x_reg   [0:CS];
    logic signed [XW-1:0] cr_y_reg   [0:CS];
    logic signed [ZW-1:0] cr_z_reg   [0:CS];
    logic signed [XW-1:0] cr_x_next  [1:CS];
    logic signed [XW-1:0] cr_y_next  [1:CS];
    logic signed [ZW-1:0] cr_z_next  [1:CS];

    always_comb
    begin
        logic signed [XW-1:0] dx, dy;
        logic signed [ZW-1:0] arc;
        for (int i = 0; i < CS; i++)
        begin
            dx  = cr_y_reg[i] >>> (i & 31);
            dy  = cr_x_reg[i] >>> (i & 31);
            arc = $signed(ZW'(cdm_pkg::arc_q30(5'(i & 31))));
            if (!cr_z_reg[i][ZW-1])
            begin
                cr_x_next[i+1] = cr_x_reg[i] - dx;
                cr_y_next[i+1] = cr_y_reg[i] + dy;
                cr_z_next[i+1] = cr_z_reg[i] - arc;
            end
            else
            begin
                cr_x_next[i+1] = cr_x_reg[i] + dx;
                cr_y_next[i+1] = cr_y_reg[i] - dy;
                cr_z_next[i+1] = cr_z_reg[i] + arc;
            end
        end
    end

    // output scaling
    logic                 om_vld_reg;
    side_t                om_sd_reg;
    logic signed [PW-1:0] om_pc_reg, om_ps_reg;
    logic signed [15:0]   sat_c, sat_s;
    cdm_pkg::result_t     result_next;
    logic                 done_reg;
    cdm_pkg::result_t     result_reg;

    localparam int OSH_C = cdm_pkg::OSH;

    function automatic logic signed [15:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0]     t;
        logic signed [PW-OSH_C-1:0] v;
        t = p + $signed(PW'(1) << (cdm_pkg::OSH - 1));
        v = t[PW-1:cdm_pkg::OSH];
        if (v > $signed((PW-OSH_C)'(32767)))
            return 16'sh7fff;
        else if (v < -$signed((PW-OSH_C)'(32768)))
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    always_comb
    begin
        sat_c = round_sat(om_pc_reg);
        sat_s = round_sat(om_ps_reg);
        if (om_sd_reg.origin)
        begin
            result_next.disk_x = '0;
            result_next.disk_y = '0;
        end
        else if (om_sd_reg.xbr)
        begin
            result_next.disk_x = sat_c;
            result_next.disk_y = sat_s;
        end
        else
        begin
            result_next.disk_x = sat_s;
            result_next.disk_y = sat_c;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                dv_vld_reg[k] <= 1'b0;
            for (int i = 0; i <= CS; i++)
                cr_vld_reg[i] <= 1'b0;
            am_vld_reg <= 1'b0;
            om_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= start && !busy;
            for (int k = 0; k < QW; k++)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            am_vld_reg    <= dv_vld_reg[QW];
            cr_vld_reg[0] <= am_vld_reg;
            for (int i = 0; i < CS; i++)
                cr_vld_reg[i+1] <= cr_vld_reg[i];
            om_vld_reg <= cr_vld_reg[CS];
            done_reg   <= om_vld_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dv_sd_reg[0]  <= s0_next;
        dv_rem_reg[0] <= num0;
        dv_den_reg[0] <= den0;
        dv_q_reg[0]   <= '0;
        for (int k = 0; k < QW; k++)
        begin
            dv_sd_reg[k+1]  <= dv_sd_reg[k];
            dv_den_reg[k+1] <= dv_den_reg[k];
            dv_rem_reg[k+1] <= dv_rem_next[k+1];
            dv_q_reg[k+1]   <= dv_q_next[k+1];
        end
        am_sd_reg   <= dv_sd_reg[QW];
        am_prod_reg <= cdm_pkg::PROD_W'(dv_q_reg[QW]) * cdm_pkg::PROD_W'(cdm_pkg::PI4_Q30);
        cr_sd_reg[0] <= am_sd_reg;
        cr_x_reg[0]  <= $signed(cdm_pkg::GAIN_Q30);
        cr_y_reg[0]  <= '0;
        cr_z_reg[0]  <= am_sd_reg.neg ? -$signed(ZW'(phi)) : $signed(ZW'(phi));
        for (int i = 0; i < CS; i++)
        begin
            cr_sd_reg[i+1] <= cr_sd_reg[i];
            cr_x_reg[i+1]  <= cr_x_next[i+1];
            cr_y_reg[i+1]  <= cr_y_next[i+1];
            cr_z_reg[i+1]  <= cr_z_next[i+1];
        end
        om_sd_reg  <= cr_sd_reg[CS];
        om_pc_reg  <= PW'(cr_sd_reg[CS].r) * PW'(cr_x_reg[CS]);
        om_ps_reg  <= PW'(cr_sd_reg[CS].r) * PW'(cr_y_reg[CS]);
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* sim/concentric_disk_map_tb.sv */
// Testbench for concentric_disk_map: directed table plus random requests, each result checked
// against a typed point or a fixed-point disk-map predictor. Depends on cdm_pkg.
`default_nettype none
module concentric_disk_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = cdm_pkg::CORDIC_STEPS + 36;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    cdm_pkg::request_t request = '0;
    logic              done;
    cdm_pkg::result_t  result;

    cdm_pkg::result_t  pending_points[$];
    int       errors = 0;
    int       checked = 0;
    int       sent = 0;
    bit       stim_done = 1'b0;

    concentric_disk_map i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arc_at(int k);
        longint t [32] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535,
            32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
        return t[k];
    endfunction

    function automatic logic signed [15:0] scale_sat(longint r, longint t);
        longint v;
        v = asr(r * t + (longint'(1) <<< (cdm_pkg::OSH - 1)), cdm_pkg::OSH);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic cdm_pkg::result_t disk_point(cdm_pkg::request_t q);
        cdm_pkg::result_t p;
        longint  ox, oy, r, num, den, ratio, phi, cx, sy, zz, dx, dy;
        longint  ax, ay;
        bit      xbr, neg;
        ox = 2 * longint'(q.sample_u0) - (longint'(1) <<< cdm_pkg::SAMPLE_BITS);
        oy = 2 * longint'(q.sample_u1) - (longint'(1) <<< cdm_pkg::SAMPLE_BITS);
        p = '0;
        if (ox == 0 && oy == 0)
            return p;
        ax = ox < 0 ? -ox : ox;
        ay = oy < 0 ? -oy : oy;
        xbr = ax > ay;
        r = xbr ? ox : oy;
        num = xbr ? oy : ox;
        den = xbr ? ox : oy;
        neg = (num < 0) != (den < 0);
        ratio = ((num < 0 ? -num : num) <<< cdm_pkg::FRAC_BITS) / (den < 0 ? -den : den);
        phi = (ratio * longint'(cdm_pkg::PI4_Q30) + (longint'(1) <<< (cdm_pkg::FRAC_BITS - 1)))
              >>> cdm_pkg::FRAC_BITS;
        if (neg)
            phi = -phi;
        cx = longint'(cdm_pkg::GAIN_Q30);
        sy = 0;
        zz = phi;
        for (int i = 0; i < cdm_pkg::CORDIC_STEPS; i++)
        begin
            dx = asr(sy, i & 31);
            dy = asr(cx, i & 31);
            if (zz >= 0)
            begin
                cx -= dx;
                sy += dy;
                zz -= arc_at(i & 31);
            end
            else
            begin
                cx += dx;
                sy -= dy;
                zz += arc_at(i & 31);
            end
        end
        p.disk_x = xbr ? scale_sat(r, cx) : scale_sat(r, sy);
        p.disk_y = xbr ? scale_sat(r, sy) : scale_sat(r, cx);
        return p;
    endfunction

    task automatic report_mismatch(string what, cdm_pkg::result_t got,
                                   cdm_pkg::result_t want);
        $display("mismatch %s: got x=%0d y=%0d want x=%0d y=%0d", what,
                 got.disk_x, got.disk_y, want.disk_x, want.disk_y);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cdm_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected", result, '0);
            else
            begin
                want = pending_points.pop_front();
                checked++;
                if (result.disk_x !== want.disk_x || result.disk_y !== want.disk_y)
                    report_mismatch("point", result, want);
            end
        end
    end

    // directed rows: u0, u1, flag for a typed point, typed point where obvious
    typedef struct {
        logic [15:0]      u0;
        logic [15:0]      u1;
        bit               typed;
        cdm_pkg::result_t point;
    } row_t;

    row_t rows [] = '{
        '{16'h8000, 16'h8000, 1, '{16'sd0, 16'sd0}},
        '{16'hFFFF, 16'h8000, 0, '0},
        '{16'h0000, 16'h8000, 0, '0},
        '{16'h8000, 16'hFFFF, 0, '0},
        '{16'h8000, 16'h0000, 0, '0},
        '{16'h0000, 16'h0000, 0, '0},
        '{16'hFFFF, 16'hFFFF, 0, '0},
        '{16'h0000, 16'hFFFF, 0, '0},
        '{16'hFFFF, 16'h0000, 0, '0},
        '{16'hC000, 16'hC000, 0, '0},
        '{16'h4000, 16'hC000, 0, '0},
        '{16'h8001, 16'h8000, 0, '0},
        '{16'h8000, 16'h7FFF, 0, '0},
        '{16'h7FFF, 16'h8001, 0, '0},
        '{16'hAAAA, 16'h5555, 0, '0},
        '{16'h5555, 16'hAAAA, 0, '0},
        '{16'hFFFF, 16'h8001, 0, '0},
        '{16'h0001, 16'hFFFE, 0, '0}
    };

    task automatic send(cdm_pkg::request_t q, cdm_pkg::result_t want);
        request <= q;
        start <= 1'b1;
        pending_points.push_back(want);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(99) < 60 ? 0 :
            ($urandom_range(99) < 90 ? $urandom_range(1, 3) : $urandom_range(10, 80));
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        cdm_pkg::request_t q;
        int       wait_cycles;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            q.sample_u0 = rows[i].u0;
            q.sample_u1 = rows[i].u1;
            send(q, rows[i].typed ? rows[i].point : disk_point(q));
            if (i % 5 == 4)
                idle_gap();
        end
        for (int i = 0; i < 1800; i++)
        begin
            case ($urandom_range(9))
                0: q = {16'($urandom_range(3) + 16'h7FFE), 16'($urandom)};
                1: q = {16'($urandom), 16'($urandom)};
                2:
                begin
                    q.sample_u0 = 16'($urandom);
                    q.sample_u1 = $urandom_range(1) ? q.sample_u0 :
                                  16'(17'h10000 - 17'(q.sample_u0));
                end
                default: q = cdm_pkg::request_t'($urandom);
            endcase
            if (i == 900)
            begin
                start <= 1'b0;
                while (pending_points.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            send(q, disk_point(q));
            if (i % 200 >= 40)
                idle_gap();
        end
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_points.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 8) @(posedge clk);
        $display("%0d requests sent, %0d points checked (origin, axes, ties, extremes, random)",
                 sent, checked);
        if (errors == 0 && pending_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/cdm_pkg.sv
hw/rtl/concentric_disk_map.sv
sim/concentric_disk_map_tb.sv
